/* rtl/core/bdhc_pkg.sv */
`default_nettype none

package bdhc_pkg;

    // Number of debounced buttons and width of each integrating counter.
    localparam int NUM_BUTTONS = 6;
    localparam int COUNT_WIDTH = 8;

    // Fixed field widths of the channel words.
    localparam int CMD_W    = 2;
    localparam int PINS_W   = 6;
    localparam int BUTTON_W = 3;
    localparam int MASK_W   = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Widths used to compare counters against the 8-bit registers and to
    // line up the button vectors with the 6-bit pin and mask fields.
    localparam int CMP_W = (COUNT_WIDTH > CFG_DATA_W) ? COUNT_WIDTH : CFG_DATA_W;
    localparam int PAD_W = (NUM_BUTTONS > PINS_W) ? NUM_BUTTONS : PINS_W;
    localparam int BIDX_W = (BUTTON_W > 5) ? BUTTON_W : 5;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ACK   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CEILING   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_TH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_TH = 2'd2;

    // Configuration reset values.
    localparam logic [CFG_DATA_W-1:0] CEILING_RESET    = 8'd10;
    localparam logic [CFG_DATA_W-1:0] PRESS_TH_RESET   = 8'd8;
    localparam logic [CFG_DATA_W-1:0] RELEASE_TH_RESET = 8'd2;

    typedef logic [COUNT_WIDTH-1:0] count_t;

endpackage

`default_nettype wire

/* rtl/core/bdhc_if.sv */
`default_nettype none

interface bdhc_req_if
    import bdhc_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [PINS_W-1:0]   pins_raw;
    logic [BUTTON_W-1:0] button;

    modport source (output valid, output command, output pins_raw, output button,
                    input ready);
    modport sink (input valid, input command, input pins_raw, input button,
                  output ready);
endinterface

interface bdhc_rsp_if
    import bdhc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [MASK_W-1:0] hold_mask;
    logic [MASK_W-1:0] click_pending_mask;

    modport source (output valid, output hold_mask, output click_pending_mask,
                    input ready);
    modport sink (input valid, input hold_mask, input click_pending_mask,
                  output ready);
endinterface

interface bdhc_cfg_if
    import bdhc_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/button_debounce_hold_click_top.sv */
// A request word accepted at a clock edge has its result word registered and valid after that edge.
// Throughput: one request word per cycle; the single result register is refilled in the same
// cycle that its word is taken, so the only stall comes from result backpressure.
// Reset (rst_n low, asynchronous): counters, hold, click and taken flags clear to zero, the
// result register empties, and the registers return to ceiling 10, press 8, release 2.
`default_nettype none

module button_debounce_hold_click_top
    import bdhc_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    bdhc_cfg_if.sink    cfg,
    bdhc_req_if.sink    request,
    bdhc_rsp_if.source  result
);

    // Configuration registers. Writes are always taken.
    logic [CFG_DATA_W-1:0] count_ceiling_reg;
    logic [CFG_DATA_W-1:0] press_threshold_reg;
    logic [CFG_DATA_W-1:0] release_threshold_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_ceiling_reg     <= CEILING_RESET;
            press_threshold_reg   <= PRESS_TH_RESET;
            release_threshold_reg <= RELEASE_TH_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_CEILING:    count_ceiling_reg     <= cfg.data;
                REG_PRESS_TH:   press_threshold_reg   <= cfg.data;
                REG_RELEASE_TH: release_threshold_reg <= cfg.data;
                default:        ;
            endcase
        end
    end

    // Per-button debounce state.
    count_t                 press_count_reg  [NUM_BUTTONS];
    count_t                 press_count_next [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] held_reg, held_next;
    logic [NUM_BUTTONS-1:0] click_reg, click_next;
    logic [NUM_BUTTONS-1:0] taken_reg, taken_next;

    // Result register. A new request word is taken whenever the result register
    // is empty or its word leaves at the same edge.
    logic              out_valid_reg;
    logic [MASK_W-1:0] hold_mask_reg, hold_mask_next;
    logic [MASK_W-1:0] pending_mask_reg, pending_mask_next;
    logic              accept;

    assign request.ready = !out_valid_reg || result.ready;
    assign accept        = request.valid && request.ready;

    // Raw pins, widened so that buttons beyond the pin field read as pressed.
    logic [PAD_W-1:0]       pins_wide;
    logic [NUM_BUTTONS-1:0] pressed;
    logic [PAD_W-1:0]       held_wide;
    logic [PAD_W-1:0]       pending_wide;
    logic [BIDX_W-1:0]      button_wide;

    assign pins_wide   = PAD_W'(request.pins_raw);
    assign pressed     = ~pins_wide[NUM_BUTTONS-1:0];
    assign button_wide = BIDX_W'(request.button);

    always_comb
    begin
        logic [CMP_W-1:0] cnt;
        logic [CMP_W-1:0] cnt_new;

        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            press_count_next[i] = press_count_reg[i];
        end
        held_next  = held_reg;
        click_next = click_reg;
        taken_next = taken_reg;
        cnt        = '0;
        cnt_new    = '0;

        case (request.command)
            CMD_TICK:
            begin
                for (int i = 0; i < NUM_BUTTONS; i++)
                begin
                    cnt = CMP_W'(press_count_reg[i]);
                    if (pressed[i])
                    begin
                        // Count up toward the ceiling, never past the counter's own maximum.
                        if ((cnt < CMP_W'(count_ceiling_reg)) && (press_count_reg[i] != '1))
                        begin
                            cnt_new = cnt + CMP_W'(1);
                        end
                        else
                        begin
                            cnt_new = cnt;
                        end
                        if (cnt_new >= CMP_W'(press_threshold_reg))
                        begin
                            held_next[i] = 1'b1;
                            // One click per press; a new click clears an old acknowledge.
                            if (!click_reg[i])
                            begin
                                click_next[i] = 1'b1;
                                taken_next[i] = 1'b0;
                            end
                        end
                    end
                    else
                    begin
                        if (cnt != '0)
                        begin
                            cnt_new = cnt - CMP_W'(1);
                        end
                        else
                        begin
                            cnt_new = cnt;
                        end
                        if (cnt_new <= CMP_W'(release_threshold_reg))
                        begin
                            held_next[i]  = 1'b0;
                            click_next[i] = 1'b0;
                            taken_next[i] = 1'b0;
                        end
                    end
                    press_count_next[i] = cnt_new[COUNT_WIDTH-1:0];
                end
            end
            CMD_ACK:
            begin
                // Indexes beyond the last button match nothing and are ignored.
                for (int i = 0; i < NUM_BUTTONS; i++)
                begin
                    if (button_wide == BIDX_W'(i))
                    begin
                        taken_next[i] = 1'b1;
                    end
                end
            end
            CMD_CLEAR:
            begin
                for (int i = 0; i < NUM_BUTTONS; i++)
                begin
                    press_count_next[i] = '0;
                end
                held_next  = '0;
                click_next = '0;
                taken_next = '0;
            end
            default:
            begin
                // The unused code leaves the state alone; its result word still reports the current masks.
            end
        endcase
    end

    // Output masks carry buttons 0 to 5 only.
    assign held_wide         = PAD_W'(held_next);
    assign pending_wide      = PAD_W'(click_next & ~taken_next);
    assign hold_mask_next    = held_wide[MASK_W-1:0];
    assign pending_mask_next = pending_wide[MASK_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                press_count_reg[i] <= '0;
            end
            held_reg      <= '0;
            click_reg     <= '0;
            taken_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                for (int i = 0; i < NUM_BUTTONS; i++)
                begin
                    press_count_reg[i] <= press_count_next[i];
                end
                held_reg      <= held_next;
                click_reg     <= click_next;
                taken_reg     <= taken_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The result payload follows the accepted word and needs no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_mask_reg    <= hold_mask_next;
            pending_mask_reg <= pending_mask_next;
        end
    end

    assign result.valid              = out_valid_reg;
    assign result.hold_mask          = hold_mask_reg;
    assign result.click_pending_mask = pending_mask_reg;

endmodule

`default_nettype wire
